// ===== rtl/dcfp_pkg.sv =====
package dcfp_pkg;

  localparam int unsigned LengthBitsDefault = 8;
  localparam int unsigned CfgIndexW         = 8;
  localparam int unsigned CfgDataW          = 48;

  localparam logic [7:0] CharOpen  = 8'h21;
  localparam logic [7:0] CharClose = 8'h23;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;

  localparam logic       CmdByte = 1'b0;
  localparam logic       CmdTick = 1'b1;

  localparam int unsigned KeyLen   = 4;
  localparam logic [2:0]  ReplyLen = 3'd6;

  localparam logic [15:0] TimeoutReset = 16'd1000;
  localparam logic [31:0] KeywordReset = 32'h4349414F;
  localparam logic [47:0] ReplyReset   = 48'h21484F4C4123;

  typedef enum logic [CfgIndexW-1:0] {
    CfgTimeout = 8'd0,
    CfgKeyword = 8'd1,
    CfgReply   = 8'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    KindReply   = 2'd0,
    KindEnd     = 2'd1,
    KindTimeout = 2'd2
  } kind_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] tx_byte;
    logic [7:0] frame_length;
    logic       matched;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [31:0] keyword;
    logic [47:0] reply_text;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] frame_length;
    logic       matched;
  } event_t;

  function automatic out_t event_to_result(event_t ev);
    out_t r;
    r.kind         = ev.kind;
    r.tx_byte      = 8'h00;
    r.frame_length = ev.frame_length;
    r.matched      = ev.matched;
    r.last         = ~ev.matched;
    return r;
  endfunction

endpackage

// ===== rtl/dcfp_cfg_regs.sv =====
module dcfp_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [dcfp_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [dcfp_pkg::CfgDataW-1:0]    cfg_data_i,
  output dcfp_pkg::cfg_t                   cfg_o
);

  dcfp_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dcfp_pkg::CfgTimeout: cfg_d.timeout_ticks = cfg_data_i[15:0];
        dcfp_pkg::CfgKeyword: cfg_d.keyword       = cfg_data_i[31:0];
        dcfp_pkg::CfgReply:   cfg_d.reply_text    = cfg_data_i[47:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks <= dcfp_pkg::TimeoutReset;
      cfg_q.keyword       <= dcfp_pkg::KeywordReset;
      cfg_q.reply_text    <= dcfp_pkg::ReplyReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/dcfp_parser.sv =====
module dcfp_parser #(
  parameter int unsigned LENGTH_BITS = dcfp_pkg::LengthBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  dcfp_pkg::in_t    item_i,
  input  dcfp_pkg::cfg_t   cfg_i,
  output dcfp_pkg::event_t ev_o
);

  localparam logic [LENGTH_BITS-1:0] LenMax = '1;
  localparam logic [LENGTH_BITS-1:0] LenKey = LENGTH_BITS'(dcfp_pkg::KeyLen);

  logic                   in_frame_q, in_frame_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic                   match_q, match_d;
  logic [15:0]            time_q, time_d;
  logic [7:0]             key_byte;
  logic [16:0]            len_wide;

  assign key_byte = 8'(cfg_i.keyword >> {~len_q[1:0], 3'b000});
  assign len_wide = 17'(len_q);

  always_comb begin
    in_frame_d = in_frame_q;
    len_d      = len_q;
    match_d    = match_q;
    time_d     = time_q;
    ev_o       = '0;
    ev_o.kind  = dcfp_pkg::KindEnd;
    if (take_i) begin
      priority if (item_i.cmd == dcfp_pkg::CmdTick) begin
        if (in_frame_q) begin
          if (time_q <= 16'd1) begin
            in_frame_d = 1'b0;
            len_d      = '0;
            match_d    = 1'b1;
            time_d     = '0;
            ev_o.valid = 1'b1;
            ev_o.kind  = dcfp_pkg::KindTimeout;
          end else begin
            time_d = time_q - 16'd1;
          end
        end
      end else if (item_i.rx_byte == dcfp_pkg::CharCr ||
                   item_i.rx_byte == dcfp_pkg::CharLf) begin
        // line endings carry nothing
      end else if (item_i.rx_byte == dcfp_pkg::CharOpen) begin
        in_frame_d = 1'b1;
        len_d      = '0;
        match_d    = 1'b1;
        time_d     = cfg_i.timeout_ticks;
      end else if (in_frame_q) begin
        if (item_i.rx_byte == dcfp_pkg::CharClose) begin
          ev_o.valid        = 1'b1;
          ev_o.kind         = dcfp_pkg::KindEnd;
          ev_o.frame_length = (len_wide > 17'd255) ? 8'hFF : len_wide[7:0];
          ev_o.matched      = match_q && (len_q == LenKey);
          in_frame_d        = 1'b0;
          len_d             = '0;
          match_d           = 1'b1;
          time_d            = '0;
        end else begin
          if (len_q >= LenKey || key_byte != item_i.rx_byte) begin
            match_d = 1'b0;
          end
          if (len_q != LenMax) begin
            len_d = len_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      len_q      <= '0;
      match_q    <= 1'b1;
      time_q     <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      len_q      <= len_d;
      match_q    <= match_d;
      time_q     <= time_d;
    end
  end

endmodule

// ===== rtl/dcfp_emitter.sv =====
module dcfp_emitter (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dcfp_pkg::event_t ev_i,
  input  dcfp_pkg::cfg_t   cfg_i,
  output logic             busy_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output dcfp_pkg::out_t   out_item_o
);

  dcfp_pkg::out_t   out_q, out_d, reply_item;
  logic             out_valid_q, out_valid_d;
  dcfp_pkg::event_t pend_q, pend_d;
  logic             pend_valid_q, pend_valid_d;
  logic [2:0]       rep_cnt_q, rep_cnt_d;
  logic             load;

  assign load   = !out_valid_q || !out_stall_i;
  assign busy_o = pend_valid_q || (rep_cnt_q != 3'd0);

  always_comb begin
    reply_item              = '0;
    reply_item.kind         = dcfp_pkg::KindReply;
    reply_item.tx_byte      = 8'(cfg_i.reply_text >> {rep_cnt_q - 3'd1, 3'b000});
    reply_item.last         = (rep_cnt_q == 3'd1);
  end

  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    rep_cnt_d    = rep_cnt_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      priority if (rep_cnt_q != 3'd0) begin
        out_d       = reply_item;
        out_valid_d = 1'b1;
        rep_cnt_d   = rep_cnt_q - 3'd1;
      end else if (pend_valid_q) begin
        out_d        = dcfp_pkg::event_to_result(pend_q);
        out_valid_d  = 1'b1;
        pend_valid_d = 1'b0;
        rep_cnt_d    = pend_q.matched ? dcfp_pkg::ReplyLen : 3'd0;
      end else if (ev_i.valid) begin
        out_d       = dcfp_pkg::event_to_result(ev_i);
        out_valid_d = 1'b1;
        rep_cnt_d   = ev_i.matched ? dcfp_pkg::ReplyLen : 3'd0;
      end
    end else if (ev_i.valid) begin
      pend_d       = ev_i;
      pend_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      rep_cnt_q    <= 3'd0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
      rep_cnt_q    <= rep_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_reply_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rep_cnt_q != 3'd0) |-> out_valid_q)
    else $error("reply bytes pending without a result in the output register");

  a_pend_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("pending event held while output register empty");

  a_no_event_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_i.valid |-> (!pend_valid_q && rep_cnt_q == 3'd0))
    else $error("event arrived while emitter busy");

  a_reply_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_cnt_q <= dcfp_pkg::ReplyLen)
    else $error("reply counter out of range");

  a_reply_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == dcfp_pkg::KindReply) |->
      (out_q.last == (rep_cnt_q == 3'd0)))
    else $error("last flag does not match final reply byte");

endmodule

// ===== rtl/delimited_command_frame_parser.sv =====
// results: the event an item causes is registered in the output register
// throughput: one item per cycle when input is not held; a matching frame end holds input
// while the six reply bytes leave, and an event meeting a stalled output is parked in a
// one-entry slot that holds input until it moves on
// reset: no frame open, output empty, registers back to timeout 1000, "CIAO", "!HOLA#"
module delimited_command_frame_parser #(
  parameter int unsigned LENGTH_BITS = dcfp_pkg::LengthBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  dcfp_pkg::in_t                  in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output dcfp_pkg::out_t                 out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dcfp_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [dcfp_pkg::CfgDataW-1:0]  cfg_data_i
);

  dcfp_pkg::cfg_t   cfg;
  dcfp_pkg::event_t ev;
  logic             busy;
  logic             take;

  assign in_stall_o = busy;
  assign take       = in_valid_i && !busy;

  dcfp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dcfp_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .item_i (in_item_i),
    .cfg_i  (cfg),
    .ev_o   (ev)
  );

  dcfp_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_i        (ev),
    .cfg_i       (cfg),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
